### hdl/nalfu_pkg.sv
// ============================================================================
// nalfu_pkg
// Shared widths, codes and constants of the H.264 FU-A packet descriptor block.
// ============================================================================
package nalfu_pkg;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 14;
    localparam int unsigned MTU_W  = 14;

    // configuration port
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_IDX_MTU = 1'b0;

    // packet size budget
    localparam int unsigned MTU_OVERHEAD    = 16;
    localparam int unsigned SINGLE_HDR_ROOM = 5;
    localparam int unsigned FU_HDR_ROOM     = 2;
    localparam int unsigned MTU_FLOOR       = 32;
    localparam int unsigned MTU_MIN =
        (MTU_FLOOR > MTU_OVERHEAD + 16) ? MTU_FLOOR : MTU_OVERHEAD + 16;
    localparam logic [MTU_W-1:0] MTU_RESET = 14'd1400;

    // Annex B and FU-A byte codes
    localparam logic [BYTE_W-1:0] START_CODE_TAIL = 8'h01;
    localparam logic [BYTE_W-1:0] NRI_MASK        = 8'hE0;
    localparam logic [BYTE_W-1:0] TYPE_MASK       = 8'h1F;
    localparam logic [BYTE_W-1:0] FU_A_TYPE       = 8'd28;
    localparam logic [BYTE_W-1:0] FU_START_BIT    = 8'h80;
    localparam logic [BYTE_W-1:0] FU_END_BIT      = 8'h40;

    // descriptor kinds
    typedef enum logic [1:0] {
        KIND_SINGLE    = 2'd0,
        KIND_FU_START  = 2'd1,
        KIND_FU_MIDDLE = 2'd2,
        KIND_FU_END    = 2'd3
    } packet_kind_t;

endpackage

### hdl/nalfu_if.sv
// ============================================================================
// nalfu_if
// Valid/ready channels: Annex B byte stream in, packet descriptors out.
// ============================================================================

// byte stream channel
interface nalfu_stream_if;
    logic                          valid;
    logic                          ready;
    logic [nalfu_pkg::BYTE_W-1:0]  stream_byte;
    logic                          buffer_last;

    modport source (output valid, output stream_byte, output buffer_last, input ready);
    modport sink   (input valid, input stream_byte, input buffer_last, output ready);
endinterface

// packet descriptor channel
interface nalfu_desc_if #(
    parameter int OFFSET_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [OFFSET_BITS-1:0]        payload_offset;
    logic [nalfu_pkg::LEN_W-1:0]   payload_length;
    nalfu_pkg::packet_kind_t       packet_kind;
    logic [nalfu_pkg::BYTE_W-1:0]  fu_indicator;
    logic [nalfu_pkg::BYTE_W-1:0]  fu_header;
    logic                          advance_timestamp;
    logic                          last_of_run;

    modport source (
        output valid, output payload_offset, output payload_length, output packet_kind,
        output fu_indicator, output fu_header, output advance_timestamp,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input payload_offset, input payload_length, input packet_kind,
        input fu_indicator, input fu_header, input advance_timestamp,
        input last_of_run, output ready
    );
endinterface

### hdl/h264_nal_fu_a_packetizer.sv
// ============================================================================
// h264_nal_fu_a_packetizer
// Scans an Annex B byte stream and describes each NAL unit as RTP packets.
// ============================================================================
// One byte is accepted per clock while the descriptor queue has room. Start
// codes (00 00 01 or 00 00 00 01) are found through a three-byte lookahead, so
// a NAL unit's descriptors come out a few bytes after its data. A unit of at
// most mtu-21 bytes gives one single-NAL descriptor; a longer one gives FU-A
// fragments of at most mtu-18 payload bytes that skip the NAL header. Each
// accepted byte passes an input register and combinational logic, and its zero
// to two descriptors are written into a four-entry output queue as it leaves
// that register; the byte stream is held off only while that queue has fewer
// than two free entries. The mtu register sits at byte address 0 of the APB
// port; writes below 32 are ignored.
// ============================================================================
module h264_nal_fu_a_packetizer #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    nalfu_stream_if.sink                         stream,
    nalfu_desc_if.source                         descriptor,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nalfu_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [nalfu_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [nalfu_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int unsigned LEN_W   = nalfu_pkg::LEN_W;
    localparam int unsigned MTU_W   = nalfu_pkg::MTU_W;
    localparam int unsigned BYTE_W  = nalfu_pkg::BYTE_W;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;
    localparam logic [MTU_W-1:0] SINGLE_CUT =
        MTU_W'(nalfu_pkg::MTU_OVERHEAD + nalfu_pkg::SINGLE_HDR_ROOM);
    localparam logic [MTU_W-1:0] FRAG_CUT =
        MTU_W'(nalfu_pkg::MTU_OVERHEAD + nalfu_pkg::FU_HDR_ROOM);

    // open NAL unit tracking
    typedef struct packed {
        logic                   in_nal;
        logic                   frag;
        logic                   fu_started;
        logic [BYTE_W-1:0]      header;
        logic [OFFSET_BITS-1:0] nal_start;
        logic [OFFSET_BITS-1:0] chunk_start;
        logic [LEN_W-1:0]       chunk_len;
    } nal_t;

    typedef struct packed {
        logic                    valid;
        logic [OFFSET_BITS-1:0]  off;
        logic [LEN_W-1:0]        len;
        nalfu_pkg::packet_kind_t kind;
        logic [BYTE_W-1:0]       header;
    } emit_t;

    typedef struct packed {
        nal_t  st;
        emit_t em;
    } commit_t;

    typedef struct packed {
        nal_t  st;
        emit_t e0;
        emit_t e1;
    } close_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0]  off;
        logic [LEN_W-1:0]        len;
        nalfu_pkg::packet_kind_t kind;
        logic [BYTE_W-1:0]       ind;
        logic [BYTE_W-1:0]       hdr;
        logic                    adv;
        logic                    last;
    } desc_t;

    // one byte joins the open NAL unit
    function automatic commit_t commit_byte(nal_t s, logic en, logic [BYTE_W-1:0] b,
                                            logic [LEN_W-1:0] single_lim,
                                            logic [LEN_W-1:0] frag_lim);
        commit_t r;
        r.st = s;
        r.em = '0;
        if (en && s.in_nal)
        begin
            if (!s.frag)
            begin
                if (s.chunk_len == '0)
                    r.st.header = b;
                if (s.chunk_len < single_lim)
                    r.st.chunk_len = s.chunk_len + LEN_W'(1);
                else
                begin
                    // too long for one packet: switch to fragments past the header
                    r.st.frag        = 1'b1;
                    r.st.fu_started  = 1'b0;
                    r.st.chunk_start = s.nal_start + OFFSET_BITS'(1);
                end
            end
            else if (s.chunk_len >= frag_lim)
            begin
                r.em.valid       = 1'b1;
                r.em.off         = s.chunk_start;
                r.em.len         = s.chunk_len;
                r.em.kind        = s.fu_started ? nalfu_pkg::KIND_FU_MIDDLE
                                                : nalfu_pkg::KIND_FU_START;
                r.em.header      = s.header;
                r.st.fu_started  = 1'b1;
                r.st.chunk_start = s.chunk_start + OFFSET_BITS'(s.chunk_len);
                r.st.chunk_len   = LEN_W'(1);
            end
            else
                r.st.chunk_len = s.chunk_len + LEN_W'(1);
        end
        return r;
    endfunction

    // close the open NAL unit and describe what is left of it
    function automatic close_t close_nal(nal_t s, logic en);
        close_t r;
        r.st = s;
        r.e0 = '0;
        r.e1 = '0;
        if (en && s.in_nal)
        begin
            if (!s.frag)
            begin
                if (s.chunk_len != '0)
                begin
                    r.e0.valid  = 1'b1;
                    r.e0.off    = s.nal_start;
                    r.e0.len    = s.chunk_len;
                    r.e0.kind   = nalfu_pkg::KIND_SINGLE;
                    r.e0.header = s.header;
                end
            end
            else if (!s.fu_started)
            begin
                // whole FU payload in one chunk: split off the last byte as the end
                r.e0.valid  = 1'b1;
                r.e0.off    = s.chunk_start;
                r.e0.len    = s.chunk_len - LEN_W'(1);
                r.e0.kind   = nalfu_pkg::KIND_FU_START;
                r.e0.header = s.header;
                r.e1.valid  = 1'b1;
                r.e1.off    = s.chunk_start + OFFSET_BITS'(s.chunk_len - LEN_W'(1));
                r.e1.len    = LEN_W'(1);
                r.e1.kind   = nalfu_pkg::KIND_FU_END;
                r.e1.header = s.header;
            end
            else
            begin
                r.e0.valid  = 1'b1;
                r.e0.off    = s.chunk_start;
                r.e0.len    = s.chunk_len;
                r.e0.kind   = nalfu_pkg::KIND_FU_END;
                r.e0.header = s.header;
            end
            r.st.in_nal     = 1'b0;
            r.st.frag       = 1'b0;
            r.st.fu_started = 1'b0;
            r.st.chunk_len  = '0;
        end
        return r;
    endfunction

    // descriptor fields from an emission
    function automatic desc_t make_desc(emit_t e, logic last);
        desc_t d;
        d.off  = e.off;
        d.len  = e.len;
        d.kind = e.kind;
        d.last = last;
        d.adv  = (e.kind == nalfu_pkg::KIND_SINGLE) || (e.kind == nalfu_pkg::KIND_FU_END);
        if (e.kind == nalfu_pkg::KIND_SINGLE)
        begin
            d.ind = '0;
            d.hdr = '0;
        end
        else
        begin
            d.ind = (e.header & nalfu_pkg::NRI_MASK) | nalfu_pkg::FU_A_TYPE;
            d.hdr = e.header & nalfu_pkg::TYPE_MASK;
            if (e.kind == nalfu_pkg::KIND_FU_START)
                d.hdr = d.hdr | nalfu_pkg::FU_START_BIT;
            if (e.kind == nalfu_pkg::KIND_FU_END)
                d.hdr = d.hdr | nalfu_pkg::FU_END_BIT;
        end
        return d;
    endfunction

    // registers
    logic [MTU_W-1:0]       mtu_reg,        mtu_next;
    logic [LEN_W-1:0]       single_lim_reg, single_lim_next;
    logic [LEN_W-1:0]       frag_lim_reg,   frag_lim_next;
    logic [OFFSET_BITS-1:0] pos_reg,        pos_next;
    logic [3*BYTE_W-1:0]    la_reg,         la_next;
    logic [1:0]             la_cnt_reg,     la_cnt_next;
    nal_t                   nal_reg,        nal_next;
    logic                   s_valid_reg,    s_valid_next;
    logic [BYTE_W-1:0]      s_byte_reg;
    logic                   s_last_reg;
    desc_t                  q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]     q_wr_reg,       q_wr_next;
    logic [Q_PTR_W-1:0]     q_rd_reg,       q_rd_next;
    logic [Q_CNT_W-1:0]     q_cnt_reg,      q_cnt_next;

    // step intermediates
    logic                   is_start;
    logic                   q_room;
    logic                   fire;
    logic                   pop;
    commit_t                c0, c1, c2, c3;
    close_t                 cl0, cl1;
    nal_t                   st1;
    logic [3*BYTE_W-1:0]    la1;
    logic [1:0]             cnt1;
    emit_t                  cm, ce0, ce1;
    emit_t                  slot0, slot1;
    desc_t                  d0, d1, head;
    logic [1:0]             n_push;
    logic                   cfg_write;
    logic [MTU_W-1:0]       cfg_mtu;

    // ------------------------------------------------------------------------
    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[nalfu_pkg::CFG_ADDR_W-1] == nalfu_pkg::REG_IDX_MTU);
    assign cfg_mtu   = pwdata[MTU_W-1:0];

    always_comb
    begin
        mtu_next        = mtu_reg;
        single_lim_next = single_lim_reg;
        frag_lim_next   = frag_lim_reg;
        if (cfg_write && (cfg_mtu >= MTU_W'(nalfu_pkg::MTU_MIN)))
        begin
            mtu_next        = cfg_mtu;
            single_lim_next = LEN_W'(cfg_mtu - SINGLE_CUT);
            frag_lim_next   = LEN_W'(cfg_mtu - FRAG_CUT);
        end
    end

    always_comb
    begin
        if (paddr[nalfu_pkg::CFG_ADDR_W-1] == nalfu_pkg::REG_IDX_MTU)
            prdata = nalfu_pkg::CFG_DATA_W'(mtu_reg);
        else
            prdata = '0;
    end

    // ------------------------------------------------------------------------
    // input register handshake
    assign q_room       = q_cnt_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign fire         = s_valid_reg && q_room;
    assign stream.ready = !s_valid_reg || q_room;
    assign s_valid_next = (stream.valid && stream.ready) ? 1'b1 :
                          (fire ? 1'b0 : s_valid_reg);

    // ------------------------------------------------------------------------
    // one byte step: lookahead, start code, commits and closes
    assign is_start = (s_byte_reg == nalfu_pkg::START_CODE_TAIL) && (la_cnt_reg >= 2'd2) &&
                      (la_reg[2*BYTE_W-1:0] == '0);

    always_comb
    begin
        // oldest lookahead byte leaves; a zero before a start code is dropped
        c0  = commit_byte(nal_reg, (la_cnt_reg == 2'd3) &&
                          (!is_start || (la_reg[3*BYTE_W-1:2*BYTE_W] != '0)),
                          la_reg[3*BYTE_W-1:2*BYTE_W], single_lim_reg, frag_lim_reg);
        cl0 = close_nal(c0.st, is_start);
        st1 = cl0.st;
        if (is_start)
        begin
            st1.in_nal      = 1'b1;
            st1.frag        = 1'b0;
            st1.fu_started  = 1'b0;
            st1.chunk_len   = '0;
            st1.nal_start   = pos_reg + OFFSET_BITS'(1);
            st1.chunk_start = pos_reg + OFFSET_BITS'(1);
            la1             = '0;
            cnt1            = 2'd0;
        end
        else
        begin
            la1  = {la_reg[2*BYTE_W-1:0], s_byte_reg};
            cnt1 = (la_cnt_reg == 2'd3) ? 2'd3 : la_cnt_reg + 2'd1;
        end

        // end of buffer: flush lookahead, oldest first, then close
        c1  = commit_byte(st1,   s_last_reg && (cnt1 == 2'd3),
                          la1[3*BYTE_W-1:2*BYTE_W], single_lim_reg, frag_lim_reg);
        c2  = commit_byte(c1.st, s_last_reg && (cnt1 >= 2'd2),
                          la1[2*BYTE_W-1:BYTE_W], single_lim_reg, frag_lim_reg);
        c3  = commit_byte(c2.st, s_last_reg && (cnt1 >= 2'd1),
                          la1[BYTE_W-1:0], single_lim_reg, frag_lim_reg);
        cl1 = close_nal(c3.st, s_last_reg);

        if (s_last_reg)
        begin
            la_next     = '0;
            la_cnt_next = 2'd0;
            pos_next    = '0;
        end
        else
        begin
            la_next     = la1;
            la_cnt_next = cnt1;
            pos_next    = pos_reg + OFFSET_BITS'(1);
        end
        nal_next = cl1.st;
    end

    // ------------------------------------------------------------------------
    // gather emissions: at most one fragment from the commits, then the close
    always_comb
    begin
        priority if (c0.em.valid)
            cm = c0.em;
        else if (c1.em.valid)
            cm = c1.em;
        else if (c2.em.valid)
            cm = c2.em;
        else
            cm = c3.em;

        if (cl0.e0.valid)
        begin
            ce0 = cl0.e0;
            ce1 = cl0.e1;
        end
        else
        begin
            ce0 = cl1.e0;
            ce1 = cl1.e1;
        end

        if (cm.valid)
        begin
            slot0 = cm;
            slot1 = ce0;
        end
        else
        begin
            slot0 = ce0;
            slot1 = ce1;
        end

        d0     = make_desc(slot0, !slot1.valid);
        d1     = make_desc(slot1, 1'b1);
        n_push = {1'b0, slot0.valid} + {1'b0, slot1.valid};
    end

    // ------------------------------------------------------------------------
    // descriptor queue
    assign head = q_mem_reg[q_rd_reg];
    assign pop  = descriptor.valid && descriptor.ready;

    always_comb
    begin
        q_wr_next  = q_wr_reg;
        q_rd_next  = q_rd_reg + Q_PTR_W'(pop);
        q_cnt_next = q_cnt_reg - Q_CNT_W'(pop);
        if (fire)
        begin
            q_wr_next  = q_wr_reg + Q_PTR_W'(n_push);
            q_cnt_next = q_cnt_reg + Q_CNT_W'(n_push) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && slot0.valid)
            q_mem_reg[q_wr_reg] <= d0;
        if (fire && slot1.valid)
            q_mem_reg[q_wr_reg + Q_PTR_W'(1)] <= d1;
    end

    assign descriptor.valid             = q_cnt_reg != '0;
    assign descriptor.payload_offset    = head.off;
    assign descriptor.payload_length    = head.len;
    assign descriptor.packet_kind       = head.kind;
    assign descriptor.fu_indicator      = head.ind;
    assign descriptor.fu_header         = head.hdr;
    assign descriptor.advance_timestamp = head.adv;
    assign descriptor.last_of_run       = head.last;

    // ------------------------------------------------------------------------
    // input payload register
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s_byte_reg <= stream.stream_byte;
            s_last_reg <= stream.buffer_last;
        end
    end

    // control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg        <= nalfu_pkg::MTU_RESET;
            single_lim_reg <= LEN_W'(nalfu_pkg::MTU_RESET - SINGLE_CUT);
            frag_lim_reg   <= LEN_W'(nalfu_pkg::MTU_RESET - FRAG_CUT);
            pos_reg        <= '0;
            la_reg         <= '0;
            la_cnt_reg     <= 2'd0;
            nal_reg        <= '0;
            s_valid_reg    <= 1'b0;
            q_wr_reg       <= '0;
            q_rd_reg       <= '0;
            q_cnt_reg      <= '0;
        end
        else
        begin
            mtu_reg        <= mtu_next;
            single_lim_reg <= single_lim_next;
            frag_lim_reg   <= frag_lim_next;
            s_valid_reg    <= s_valid_next;
            q_wr_reg       <= q_wr_next;
            q_rd_reg       <= q_rd_next;
            q_cnt_reg      <= q_cnt_next;
            if (fire)
            begin
                pos_reg    <= pos_next;
                la_reg     <= la_next;
                la_cnt_reg <= la_cnt_next;
                nal_reg    <= nal_next;
            end
        end
    end

endmodule

### hdl/nalfu_checker.sv
// ============================================================================
// nalfu_checker
// Port-level checks of descriptor ordering, fragment continuity and the mtu register.
// ============================================================================
module nalfu_checker #(
    parameter int OFFSET_BITS = 24
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 desc_valid,
    input logic                                 desc_ready,
    input logic [OFFSET_BITS-1:0]               desc_offset,
    input logic [nalfu_pkg::LEN_W-1:0]          desc_length,
    input nalfu_pkg::packet_kind_t              desc_kind,
    input logic [nalfu_pkg::BYTE_W-1:0]         desc_indicator,
    input logic                                 psel,
    input logic                                 pwrite,
    input logic [nalfu_pkg::CFG_ADDR_W-1:0]     paddr,
    input logic [nalfu_pkg::CFG_DATA_W-1:0]     prdata
);

    logic                          desc_fire;
    logic                          is_cont;
    logic                          open_reg;
    logic [OFFSET_BITS-1:0]        end_off_reg;
    logic [nalfu_pkg::BYTE_W-1:0]  ind_reg;

    assign desc_fire = desc_valid && desc_ready;
    assign is_cont   = (desc_kind == nalfu_pkg::KIND_FU_MIDDLE) ||
                       (desc_kind == nalfu_pkg::KIND_FU_END);

    // track the fragment run seen on the descriptor channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            end_off_reg <= '0;
            ind_reg     <= '0;
        end
        else if (desc_fire)
        begin
            open_reg    <= (desc_kind == nalfu_pkg::KIND_FU_START) ||
                           (desc_kind == nalfu_pkg::KIND_FU_MIDDLE);
            end_off_reg <= desc_offset + OFFSET_BITS'(desc_length);
            ind_reg     <= desc_indicator;
        end
    end

    // a stalled descriptor stays offered
    a_desc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && !desc_ready |=> desc_valid && $stable(desc_offset))
        else $error("descriptor dropped or changed while stalled");

    // middle and end fragments only continue an open run; others only start fresh
    a_frag_order: assert property (@(posedge clk) disable iff (!rst_n)
        desc_fire |-> (is_cont == open_reg))
        else $error("fragment kind out of order");

    // a continuing fragment picks up where the previous one ended
    a_frag_contig: assert property (@(posedge clk) disable iff (!rst_n)
        desc_fire && is_cont |-> (desc_offset == end_off_reg) && (desc_indicator == ind_reg))
        else $error("fragment offset or indicator not contiguous");

    // mtu register never reads below its floor
    a_mtu_floor: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[nalfu_pkg::CFG_ADDR_W-1] == nalfu_pkg::REG_IDX_MTU) |->
        (prdata >= nalfu_pkg::CFG_DATA_W'(nalfu_pkg::MTU_MIN)) &&
        (prdata < (nalfu_pkg::CFG_DATA_W'(1) << nalfu_pkg::MTU_W)))
        else $error("mtu register holds an illegal value");

endmodule

bind h264_nal_fu_a_packetizer nalfu_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_nalfu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc_valid     (descriptor.valid),
    .desc_ready     (descriptor.ready),
    .desc_offset    (descriptor.payload_offset),
    .desc_length    (descriptor.payload_length),
    .desc_kind      (descriptor.packet_kind),
    .desc_indicator (descriptor.fu_indicator),
    .psel           (psel),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .prdata         (prdata)
);
